// ===== hw/rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam int unsigned BODY_LEN = 16;
  localparam int unsigned BODY_IDX_W = $clog2(BODY_LEN);
  localparam int unsigned BODY_CNT_W = BODY_IDX_W + 1;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC1 = 2'd1,
    PH_BODY  = 2'd2,
    PH_CHECK = 2'd3
  } phase_t;

  // One decoded frame, as handed from the parser to the output stage.
  typedef struct packed {
    logic [7:0]  sequence_res;
    logic [31:0] position;
    logic [15:0] height;
    logic [63:0] command_low;
    logic [7:0]  command_last;
  } frame_t;

endpackage

// ===== hw/rtl/sfd_parser.sv =====
`timescale 1ns / 1ps

module sfd_parser (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_rx_byte,
  input  logic            take_ok,
  output logic            res_vld,
  output sfd_pkg::frame_t res_frame
);
  import sfd_pkg::*;

  // input register
  logic       s1_vld_r, s1_vld_nxt;
  logic [7:0] s1_byte_r;
  logic       adv;

  // parse state
  phase_t                phase_r, phase_nxt;
  logic [BODY_CNT_W-1:0] body_count_r, body_count_nxt;
  logic [7:0]            running_sum_r, running_sum_nxt;
  logic [7:0]            body_store_r [BODY_LEN];
  logic                  store_we;
  logic                  is_sync;

  // only the checksum byte can produce a result, so only it waits for room
  assign adv      = s1_vld_r & (take_ok | (phase_r != PH_CHECK));
  assign in_ready = ~s1_vld_r | adv;
  assign is_sync  = (s1_byte_r == SYNC_BYTE);

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_valid && in_ready) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
    if (in_valid && in_ready) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (adv) begin
      case (phase_r)
        PH_HUNT:  phase_nxt = is_sync ? PH_SYNC1 : PH_HUNT;
        PH_SYNC1: phase_nxt = is_sync ? PH_BODY : PH_HUNT;
        PH_BODY: begin
          if (body_count_r == BODY_CNT_W'(BODY_LEN - 1)) begin
            phase_nxt = PH_CHECK;
          end
        end
        PH_CHECK: phase_nxt = PH_HUNT;
        default:  phase_nxt = PH_HUNT;
      endcase
    end
  end

  // datapath controls and result
  always_comb begin
    body_count_nxt  = body_count_r;
    running_sum_nxt = running_sum_r;
    store_we        = 1'b0;
    res_vld         = 1'b0;
    if (adv) begin
      case (phase_r)
        PH_HUNT: begin
        end
        PH_SYNC1: begin
          if (is_sync) begin
            body_count_nxt  = '0;
            running_sum_nxt = SYNC_BYTE + SYNC_BYTE;
          end
        end
        PH_BODY: begin
          store_we        = 1'b1;
          running_sum_nxt = running_sum_r + s1_byte_r;
          body_count_nxt  = body_count_r + 1'b1;
        end
        PH_CHECK: begin
          res_vld         = (s1_byte_r == running_sum_r);
          body_count_nxt  = '0;
          running_sum_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HUNT;
      body_count_r  <= '0;
      running_sum_r <= '0;
    end else begin
      phase_r       <= phase_nxt;
      body_count_r  <= body_count_nxt;
      running_sum_r <= running_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      body_store_r[body_count_r[BODY_IDX_W-1:0]] <= s1_byte_r;
    end
  end

  // fields are little-endian: first byte received lands in the low bits
  assign res_frame.sequence_res = body_store_r[0];
  assign res_frame.position     = {body_store_r[4], body_store_r[3],
                                   body_store_r[2], body_store_r[1]};
  assign res_frame.height       = {body_store_r[6], body_store_r[5]};
  assign res_frame.command_low  = {body_store_r[14], body_store_r[13],
                                   body_store_r[12], body_store_r[11],
                                   body_store_r[10], body_store_r[9],
                                   body_store_r[8],  body_store_r[7]};
  assign res_frame.command_last = body_store_r[15];

  a_check_full: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CHECK) |-> (body_count_r == BODY_CNT_W'(BODY_LEN)))
    else $error("checksum phase entered without a full body");

  a_body_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> (body_count_r < BODY_CNT_W'(BODY_LEN)))
    else $error("body count overran while capturing");

  a_idle_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HUNT || phase_r == PH_SYNC1) |-> (running_sum_r == 8'd0))
    else $error("running sum not cleared while hunting");

  a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> (phase_r == PH_CHECK && s1_vld_r && take_ok))
    else $error("result raised outside the checksum byte");

endmodule

// ===== hw/rtl/sfd_out_reg.sv =====
`timescale 1ns / 1ps

module sfd_out_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_vld,
  input  sfd_pkg::frame_t res_frame,
  output logic            take_ok,
  output logic            out_valid,
  input  logic            out_ready,
  output sfd_pkg::frame_t out_frame
);
  import sfd_pkg::*;

  logic   vld_r, vld_nxt;
  frame_t frame_r;

  // space for a new result when empty or when the held one leaves now
  assign take_ok = ~vld_r | out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take_ok) begin
      vld_nxt = res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    if (take_ok && res_vld) begin
      frame_r <= res_frame;
    end
  end

  assign out_valid = vld_r;
  assign out_frame = frame_r;

  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && take_ok) |=> vld_r)
    else $error("accepted result did not reach the output register");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_ready && !res_vld) |=> !vld_r)
    else $error("output register kept a delivered result");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && !take_ok) |-> vld_r)
    else $error("result offered while the output register had room");

endmodule

// ===== hw/rtl/sync_frame_deframer_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// in_       in   in_valid / in_ready    in_rx_byte[7:0]
// out_      out  out_valid / out_ready  out_sequence_res, out_position,
//                                       out_height, out_command_low,
//                                       out_command_last
//
// One byte per cycle unless a checksum byte is held: each transaction passes
// an input register, the parse logic and a result register, so a frame's
// result is valid on out_ once the result register has loaded it.
// Synchronous active-low reset returns to sync hunting; body bytes are not
// cleared, they are always rewritten before a frame can be reported.
// A stalled result stalls the parser only while a checksum byte waits in
// the input register; otherwise input keeps flowing.

module sync_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_sequence_res,
  output logic [31:0] out_position,
  output logic [15:0] out_height,
  output logic [63:0] out_command_low,
  output logic [7:0]  out_command_last
);
  import sfd_pkg::*;

  logic   take_ok;
  logic   res_vld;
  frame_t res_frame;
  frame_t out_frame;

  // Parser: input register, sync hunt / body capture / checksum state
  // machine and the 16-byte body store. It advances only when the output
  // stage can absorb whatever this byte may produce.
  sfd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take_ok    (take_ok),
    .res_vld    (res_vld),
    .res_frame  (res_frame)
  );

  // Result register: holds one good frame until the consumer takes it.
  sfd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_vld   (res_vld),
    .res_frame (res_frame),
    .take_ok   (take_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_frame (out_frame)
  );

  assign out_sequence_res = out_frame.sequence_res;
  assign out_position     = out_frame.position;
  assign out_height       = out_frame.height;
  assign out_command_low  = out_frame.command_low;
  assign out_command_last = out_frame.command_last;

endmodule
